// ===== src/ordered_list_table_core_macros.svh =====
// Assertion macros for the ordered list table checker.
// Used by olt_checker; expects clk_i and rst_ni in scope.
`ifndef ORDERED_LIST_TABLE_CORE_MACROS_SVH
`define ORDERED_LIST_TABLE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define OLT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define OLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/olt_pkg.sv =====
// Shared types and codes for the ordered list table.
// No dependencies; used by all modules of the block.
package olt_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Position code meaning "last entry".
  localparam logic [8:0] POS_LAST = 9'h1FF;

  // Which neighbor of the pointer the memory reads.
  typedef enum logic [1:0] {
    RA_PREV,
    RA_CUR,
    RA_NEXT
  } rsel_e;

  // Controller to datapath.
  typedef struct packed {
    logic       load;       // capture item, set pointer and slot
    logic       rd_en;
    rsel_e      rd_sel;
    logic       wr_en;      // write at pointer
    logic       wr_word;    // write data: item word (1) or read data (0)
    logic       ptr_inc;
    logic       ptr_dec;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       res_load;
    logic       res_rd;     // result carries the read data
    logic [1:0] res_status;
  } olt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic at_slot;
    logic scan_end;
    logic match;
    logic del_end;
  } olt_stat_t;

endpackage

// ===== src/ordered_list_table_core.sv =====
// Ordered list table: a list of up to CAPACITY words, head at position 0.
// Top level; instantiates olt_ctrl and olt_datapath, depends on olt_pkg.
//
// An item (opcode, value, position) is taken at a clock edge where start_i
// is high and busy_o is low. Its result (read_value_o, count_o, status_o)
// is flagged by done_o, which is high for a single cycle; the receiver
// cannot hold it off, so sample it when done_o is high. done_o rises at the
// same edge at which busy_o falls, so the strobe sits in the first cycle
// with busy_o low, and a new item may be started in that same cycle.
// Entries live in a single memory with one write and one registered
// read per cycle; each entry moved or compared takes a read state and then
// a write or compare state. busy_o stays high while the item runs:
//   insert at slot s : entries s to top move up one place (none on append or full)
//   remove           : scan from the head for a match, then close the gap
//   get              : read the entry, then load the result
//   clear            : clear the count
// Insert positions that are negative or at or past the count append; get
// at position -1 reads the last entry and any other index out of range
// returns zero. No clearing pass after reset: entries past the count are
// never read back.
module ordered_list_table_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] value_i,
  input  logic [8:0]  position_i,
  output logic        done_o,
  output logic [31:0] read_value_o,
  output logic [6:0]  count_o,
  output logic [1:0]  status_o
);
  import olt_pkg::*;

  olt_cmd_t  cmd;
  olt_stat_t stat;

  // Sequencer: decides which entry moves or is compared each cycle.
  olt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // Memory, pointer, count and result registers.
  olt_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .opcode_i     (opcode_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .status_o     (status_o)
  );

endmodule

// ===== src/olt_datapath.sv =====
// Datapath of the ordered list table: entry memory, pointer, count, result.
// Depends on olt_pkg.
module olt_datapath #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        opcode_i,
  input  logic [31:0]       value_i,
  input  logic [8:0]        position_i,
  input  olt_pkg::olt_cmd_t cmd_i,
  output olt_pkg::olt_stat_t stat_o,
  output logic [31:0]       read_value_o,
  output logic [6:0]        count_o,
  output logic [1:0]        status_o
);
  import olt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = ((CW > 9) ? CW : 9) + 1;

  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         ptr_q, ptr_d;
  logic [CW-1:0]         slot_q, slot_d;
  logic                  get_ok_q, get_ok_d;
  logic [CW-1:0]         raddr;
  logic [CW-1:0]         ptr_nx;

  logic signed [PW-1:0]  pos_x, cnt_x;
  logic                  is_neg, is_last, ge_cnt, cnt_zero;
  logic [CW-1:0]         pos_lo, get_idx;

  logic [31:0]           read_value_q, read_value_d;
  logic [6:0]            count_res_q;
  logic [1:0]            status_q;

  // Decode of the incoming position against the current count.
  assign pos_x    = {{(PW-9){position_i[8]}}, position_i};
  assign cnt_x    = {{(PW-CW){1'b0}}, count_q};
  assign is_neg   = position_i[8];
  assign is_last  = (position_i == POS_LAST);
  assign ge_cnt   = (pos_x >= cnt_x);
  assign cnt_zero = (count_q == '0);
  assign pos_lo   = pos_x[CW-1:0];

  assign slot_d   = (cnt_zero || is_neg || ge_cnt) ? count_q : pos_lo;
  assign get_ok_d = !cnt_zero && (is_last || (!is_neg && !ge_cnt));
  assign get_idx  = !get_ok_d ? '0 : (is_last ? count_q - CW'(1) : pos_lo);
  assign word_d   = DATA_WIDTH'(value_i);

  assign ptr_nx   = ptr_q + CW'(1);

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      unique case (opcode_i)
        OP_INSERT: ptr_d = count_q;
        OP_REMOVE: ptr_d = '0;
        OP_GET:    ptr_d = get_idx;
        OP_CLEAR:  ptr_d = '0;
      endcase
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_nx;
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - CW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    priority if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RA_PREV: raddr = ptr_q - CW'(1);
      RA_CUR:  raddr = ptr_q;
      RA_NEXT: raddr = ptr_nx;
      default: raddr = ptr_q;
    endcase
  end

  assign read_value_d = (cmd_i.res_rd && get_ok_q) ? 32'(rdata_q) : '0;

  // Entry store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[ptr_q[AW-1:0]] <= cmd_i.wr_word ? word_q : rdata_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ptr_q    <= '0;
      slot_q   <= '0;
      get_ok_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      if (cmd_i.load) begin
        slot_q   <= slot_d;
        get_ok_q <= get_ok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q <= word_d;
    end
    if (cmd_i.res_load) begin
      read_value_q <= read_value_d;
      count_res_q  <= 7'(count_d);
      status_q     <= cmd_i.res_status;
    end
  end

  assign stat_o.full     = (count_q == CW'(CAPACITY));
  assign stat_o.at_slot  = (ptr_q == slot_q);
  assign stat_o.scan_end = (ptr_q == count_q);
  assign stat_o.match    = (rdata_q == word_q);
  assign stat_o.del_end  = (ptr_nx == count_q);

  assign read_value_o = read_value_q;
  assign count_o      = count_res_q;
  assign status_o     = status_q;

endmodule

// ===== src/olt_ctrl.sv =====
// Controller of the ordered list table: sequences memory shifts and scans.
// Depends on olt_pkg.
module olt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         opcode_i,
  input  olt_pkg::olt_stat_t stat_i,
  output olt_pkg::olt_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               done_o
);
  import olt_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_WR  = 4'd2;
  localparam logic [3:0] S_REM_RD  = 4'd3;
  localparam logic [3:0] S_REM_CMP = 4'd4;
  localparam logic [3:0] S_DEL_RD  = 4'd5;
  localparam logic [3:0] S_DEL_WR  = 4'd6;
  localparam logic [3:0] S_GET_RD  = 4'd7;
  localparam logic [3:0] S_GET_OUT = 4'd8;
  localparam logic [3:0] S_CLR     = 4'd9;

  logic [3:0] state_q, state_d;
  logic       done_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (opcode_i)
            OP_INSERT: state_d = S_INS_RD;
            OP_REMOVE: state_d = S_REM_RD;
            OP_GET:    state_d = S_GET_RD;
            OP_CLEAR:  state_d = S_CLR;
          endcase
        end
      end
      // Move entries up one place, top first, until the pointer hits the slot.
      S_INS_RD: begin
        if (stat_i.full) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d          = S_IDLE;
        end else if (stat_i.at_slot) begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_word    = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_PREV;
          state_d      = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.ptr_dec = 1'b1;
        state_d       = S_INS_RD;
      end
      // Linear scan for the first match.
      S_REM_RD: begin
        if (stat_i.scan_end) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          state_d          = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_CUR;
          state_d      = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        if (stat_i.match) begin
          state_d = S_DEL_RD;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_REM_RD;
        end
      end
      // Close the gap: move entries down one place.
      S_DEL_RD: begin
        if (stat_i.del_end) begin
          cmd_o.cnt_dec    = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_NEXT;
          state_d      = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        state_d       = S_DEL_RD;
      end
      S_GET_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_CUR;
        state_d      = S_GET_OUT;
      end
      S_GET_OUT: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_rd     = 1'b1;
        cmd_o.res_status = ST_OK;
        state_d          = S_IDLE;
      end
      S_CLR: begin
        cmd_o.cnt_clr    = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_OK;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.res_load;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== src/olt_checker.sv =====
// Port-level checks for ordered_list_table_core, bound to the top level.
// Depends on olt_pkg and ordered_list_table_core_macros.svh.
`include "ordered_list_table_core_macros.svh"

module olt_checker #(
  parameter int CAPACITY = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [31:0] read_value_o,
  input logic [6:0]  count_o,
  input logic [1:0]  status_o
);
  import olt_pkg::*;

  `OLT_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "item taken but busy not set")
  `OLT_ASSERT_SAME(a_end_done, $fell(busy_o), done_o, "item finished without result strobe")
  `OLT_ASSERT_SAME(a_full_count, done_o && status_o == ST_FULL, count_o == 7'(CAPACITY), "full flag with count below capacity")
  `OLT_ASSERT_SAME(a_err_zero, done_o && status_o != ST_OK, read_value_o == '0, "error result with nonzero read data")

endmodule

bind ordered_list_table_core olt_checker #(.CAPACITY(CAPACITY)) u_olt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .read_value_o (read_value_o),
  .count_o      (count_o),
  .status_o     (status_o)
);
